// ----- hw/rtl/pcf_pkg.sv -----
package pcf_pkg;

    typedef struct packed {
        logic        func;
        logic [15:0] value;
        logic        last;
        logic        rx_check;
        logic [5:0]  rx_counter;
    } pcf_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
    } pcf_out_t;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       data_pec;
        logic [9:0] rem10;
        logic [1:0] last_idx;
    } pcf_frame_t;

    localparam logic        FUNC_CMD   = 1'b0;
    localparam logic        FUNC_DATA  = 1'b1;
    localparam logic [9:0]  PEC10_SEED = 10'd16;
    localparam logic [14:0] PEC15_SEED = 15'd16;
    localparam logic [9:0]  PEC10_POLY = 10'h08F;
    localparam logic [14:0] PEC15_POLY = 15'h4599;
    localparam logic [1:0]  LAST_IDX_CMD       = 2'd3;
    localparam logic [1:0]  LAST_IDX_DATA      = 2'd0;
    localparam logic [1:0]  LAST_IDX_DATA_LAST = 2'd2;

    function automatic logic [14:0] crc15_byte(input logic [14:0] rem_in, input logic [7:0] b);
        logic [14:0] rem;
        begin
            rem = rem_in ^ {b, 7'b0};
            for (int k = 0; k < 8; k++) begin
                if (rem[14]) begin
                    rem = {rem[13:0], 1'b0} ^ PEC15_POLY;
                end else begin
                    rem = {rem[13:0], 1'b0};
                end
            end
            return rem;
        end
    endfunction

    function automatic logic [9:0] crc10_shift(input logic [9:0] rem_in);
        begin
            if (rem_in[9]) begin
                return {rem_in[8:0], 1'b0} ^ PEC10_POLY;
            end
            return {rem_in[8:0], 1'b0};
        end
    endfunction

    function automatic logic [9:0] crc10_byte(input logic [9:0] rem_in, input logic [7:0] b);
        logic [9:0] rem;
        begin
            rem = rem_in ^ {b, 2'b0};
            for (int k = 0; k < 8; k++) begin
                rem = crc10_shift(rem);
            end
            return rem;
        end
    endfunction

    function automatic logic [9:0] crc10_finish(input logic [9:0] rem_in);
        logic [9:0] rem;
        begin
            rem = rem_in;
            for (int k = 0; k < 6; k++) begin
                rem = crc10_shift(rem);
            end
            return rem;
        end
    endfunction

endpackage

// ----- hw/rtl/pec_command_data_framer_core.sv -----
// Battery-monitor SPI frame builder. A command transaction (func 0) yields four bytes: the
// command high and low bytes and its 15-bit PEC, high byte first. A data transaction (func 1)
// yields its byte and advances the running 10-bit data PEC; the last data byte also yields the
// two data PEC bytes, with the receive command counter folded in when rx_check is set. A
// command restarts the data PEC. One result byte leaves per cycle while m_ready is high, through
// the single output byte port. An input register holds the next transaction while the current
// frame drains and hands it over on the cycle the final byte is taken, so frames follow without
// a gap.
module pec_command_data_framer_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pcf_pkg::pcf_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output pcf_pkg::pcf_out_t m_payload
);

    pcf_pkg::pcf_in_t    in_item_reg;
    logic [14:0]         crc_hi_reg;
    logic                in_valid_reg;
    logic                in_valid_next;
    logic                ser_ready;
    logic                load;
    logic                s_accept;
    pcf_pkg::pcf_frame_t frame;

    assign load     = in_valid_reg && ser_ready;
    assign s_ready  = !in_valid_reg || load;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_payload;
            crc_hi_reg  <= pcf_pkg::crc15_byte(pcf_pkg::PEC15_SEED, s_payload.value[15:8]);
        end
    end

    pcf_frame_calc u_frame_calc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .item    (in_item_reg),
        .crc_hi  (crc_hi_reg),
        .frame   (frame)
    );

    pcf_byte_serializer u_byte_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .frame     (frame),
        .ready_in  (ser_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but s_ready low");

    a_no_gap_between_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_payload.end_of_run && in_valid_reg) |=> m_valid)
        else $error("pending transaction not loaded after frame end");

    a_load_needs_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("frame load did not raise m_valid");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !in_valid_reg))
        else $error("outputs not idle after reset");

endmodule

// ----- hw/rtl/pcf_frame_calc.sv -----
module pcf_frame_calc (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  pcf_pkg::pcf_in_t   item,
    input  logic [14:0]        crc_hi,
    output pcf_pkg::pcf_frame_t frame
);

    logic [9:0]  data_remainder_reg;
    logic [9:0]  data_remainder_next;
    logic [9:0]  rem8;
    logic [9:0]  rem_fold;
    logic [14:0] crc_lo;
    logic [15:0] pec15;

    assign rem8     = pcf_pkg::crc10_byte(data_remainder_reg, item.value[7:0]);
    assign rem_fold = item.rx_check ? (rem8 ^ {item.rx_counter, 4'b0}) : rem8;
    assign crc_lo   = pcf_pkg::crc15_byte(crc_hi, item.value[7:0]);
    assign pec15    = {crc_lo, 1'b0};

    always_comb begin
        frame               = '0;
        data_remainder_next = data_remainder_reg;
        if (item.func == pcf_pkg::FUNC_CMD) begin
            frame.b0            = item.value[15:8];
            frame.b1            = item.value[7:0];
            frame.b2            = pec15[15:8];
            frame.b3            = pec15[7:0];
            frame.data_pec      = 1'b0;
            frame.rem10         = '0;
            frame.last_idx      = pcf_pkg::LAST_IDX_CMD;
            data_remainder_next = pcf_pkg::PEC10_SEED;
        end else if (item.last) begin
            frame.b0            = item.value[7:0];
            frame.data_pec      = 1'b1;
            frame.rem10         = rem_fold;
            frame.last_idx      = pcf_pkg::LAST_IDX_DATA_LAST;
            data_remainder_next = pcf_pkg::PEC10_SEED;
        end else begin
            frame.b0            = item.value[7:0];
            frame.data_pec      = 1'b0;
            frame.last_idx      = pcf_pkg::LAST_IDX_DATA;
            data_remainder_next = rem8;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_remainder_reg <= pcf_pkg::PEC10_SEED;
        end else if (load) begin
            data_remainder_reg <= data_remainder_next;
        end
    end

endmodule

// ----- hw/rtl/pcf_byte_serializer.sv -----
module pcf_byte_serializer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  pcf_pkg::pcf_frame_t frame,
    output logic                ready_in,
    output logic                m_valid,
    input  logic                m_ready,
    output pcf_pkg::pcf_out_t   m_payload
);

    pcf_pkg::pcf_frame_t frame_reg;
    logic                busy_reg;
    logic                busy_next;
    logic [1:0]          idx_reg;
    logic [1:0]          idx_next;
    logic                last_byte;
    logic                done;
    logic [9:0]          pec10;

    assign pec10     = pcf_pkg::crc10_finish(frame_reg.rem10);
    assign last_byte = (idx_reg == frame_reg.last_idx);
    assign m_valid   = busy_reg;
    assign done      = busy_reg && m_ready && last_byte;
    assign ready_in  = !busy_reg || done;

    always_comb begin
        case (idx_reg)
            2'd0: m_payload.out_byte = frame_reg.b0;
            2'd1: m_payload.out_byte = frame_reg.data_pec ? {6'b0, pec10[9:8]} : frame_reg.b1;
            2'd2: m_payload.out_byte = frame_reg.data_pec ? pec10[7:0] : frame_reg.b2;
            2'd3: m_payload.out_byte = frame_reg.b3;
            default: m_payload.out_byte = frame_reg.b0;
        endcase
        m_payload.end_of_run = last_byte;
    end

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end else if (busy_reg && m_ready) begin
            if (last_byte) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= frame;
        end
    end

endmodule
